### hw/rtl/hfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hfd_pkg;

    // lane numbers of the three vectors that are normalized side by side
    localparam int LANE_DIR   = 0;
    localparam int LANE_FWD   = 1;
    localparam int LANE_RIGHT = 2;

    // configuration register indexes
    localparam logic [1:0] CFG_UP_X = 2'd0;
    localparam logic [1:0] CFG_UP_Y = 2'd1;
    localparam logic [1:0] CFG_UP_Z = 2'd2;

    // reset values of the world up vector
    localparam logic signed [15:0] UP_X_RESET = 16'sd0;
    localparam logic signed [15:0] UP_Y_RESET = 16'sd16384;
    localparam logic signed [15:0] UP_Z_RESET = 16'sd0;

    // pipeline schedule: first register stage of each step, step counts
    localparam int ST_PROD    = 0;
    localparam int ST_ABS     = 1;
    localparam int ST_SQ      = 2;
    localparam int ST_SUM     = 3;
    localparam int ST_NORM    = 4;
    localparam int ROOT_STEPS = 31;
    localparam int ST_ROOT    = 5;
    localparam int ST_DIVI    = ST_ROOT + ROOT_STEPS;
    localparam int DIV_STEPS  = 31;
    localparam int ST_DIV     = ST_DIVI + 1;
    localparam int ST_SIGN    = ST_DIV + DIV_STEPS;
    localparam int ST_MUL1    = ST_SIGN + 1;
    localparam int ST_SUM1    = ST_MUL1 + 1;
    localparam int ST_MUL2    = ST_SUM1 + 1;
    localparam int ST_SUM2    = ST_MUL2 + 1;
    localparam int ST_SQC     = ST_SUM2 + 1;
    localparam int ST_ELI     = ST_SQC + 1;
    localparam int ST_ROOT2   = ST_ELI + 1;
    localparam int ST_PRE     = ST_ROOT2 + ROOT_STEPS;
    localparam int ST_CORD    = ST_PRE + 1;

    // angle constants, 2^-23 degree units
    localparam int ANGLE_LEN = 24;
    localparam logic signed [32:0] DEG90 = 33'sd754974720;
    localparam logic [28:0] ATAN_STEP [ANGLE_LEN] = '{
        29'd377487360, 29'd222843801, 29'd117744544, 29'd59768969,
        29'd30000467,  29'd15014858,  29'd7509261,   29'd3754860,
        29'd1877459,   29'd938733,    29'd469367,    29'd234683,
        29'd117342,    29'd58671,     29'd29335,     29'd14668,
        29'd7334,      29'd3667,      29'd1833,      29'd917,
        29'd458,       29'd229,       29'd115,       29'd57
    };

    localparam logic signed [32:0] Q30_ONE  = 33'sh040000000;
    localparam logic signed [17:0] AZ_LIMIT = 18'sd23040;
    localparam logic signed [17:0] EL_LIMIT = 18'sd11520;

    // working set of one item as it moves down the pipeline
    typedef struct {
        logic signed [31:0] src [3];
        logic signed [31:0] lis [3];
        logic signed [15:0] f   [3];
        logic signed [32:0] d   [3];
        logic signed [31:0] pr  [6];
        logic               ok;
        logic               neg [3][3];
        logic        [32:0] m   [3][3];
        logic        [59:0] sq  [3][3];
        logic        [61:0] m2  [3];
        logic        [4:0]  s   [3];
        logic        [62:0] sv  [3];
        logic        [62:0] sr  [3];
        logic        [30:0] n   [3];
        logic        [30:0] mm  [3][3];
        logic        [31:0] rem [3][3];
        logic        [30:0] q   [3][3];
        logic signed [31:0] u   [3][3];
        logic signed [63:0] pa  [12];
        logic signed [32:0] up  [3];
        logic signed [33:0] a;
        logic signed [33:0] b;
        logic signed [32:0] c;
        logic signed [35:0] cx  [2];
        logic signed [35:0] cy  [2];
        logic signed [32:0] cz  [2];
        logic               az_en;
        logic signed [15:0] az;
        logic signed [14:0] el;
    } pipe_t;

endpackage

`default_nettype wire

### hw/rtl/head_frame_direction_core.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one item per cycle while m_tready does not stall the output; every stage
//   is registered, the two square roots and the divisions retire one bit per stage and
//   the cordic one rotation per stage
// reset: rst_n clears all valid bits and loads world up (0, 16384, 0); data regs not reset
// no clearing pass, the block takes items in the first cycle after reset
module head_frame_direction_core
    import hfd_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // source_x, source_y, source_z, listener_x, listener_y, listener_z,
    // facing_x, facing_y, facing_z
    input  wire logic [239:0] s_tdata,
    input  wire logic         s_tvalid,
    output      logic         s_tready,
    // azimuth, elevation, zero pad bit
    output      logic [31:0]  m_tdata,
    // degenerate
    output      logic         m_tuser,
    output      logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         cfg_valid,
    output      logic         cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);

    localparam int ST_OUT = ST_CORD + CORDIC_STAGES;
    localparam int NST    = ST_OUT + 1;

    logic signed [15:0] up_reg [3];
    pipe_t              pipe_reg [NST+1];
    logic               vld_reg [NST+1];
    logic               adv [NST+1];

    // one stage of work, selected by the stage number
    function automatic pipe_t step_fn(input int k, input pipe_t p,
                                      input logic signed [15:0] wv [3]);
        pipe_t              o;
        int                 j;
        logic               big;
        logic        [61:0] t;
        logic        [4:0]  sh;
        logic        [62:0] bit_b;
        logic        [62:0] trial;
        logic        [31:0] rem2;
        logic        [61:0] mshift;
        logic signed [63:0] acc;
        logic signed [33:0] vals [3][3];
        logic signed [35:0] xin;
        logic signed [35:0] yin;
        logic signed [35:0] dx;
        logic signed [35:0] dy;
        logic signed [33:0] rz;
        logic signed [17:0] rq;
        o      = p;
        j      = 0;
        big    = 1'b0;
        t      = '0;
        sh     = '0;
        bit_b  = '0;
        trial  = '0;
        rem2   = '0;
        mshift = '0;
        acc    = '0;
        xin    = '0;
        yin    = '0;
        dx     = '0;
        dy     = '0;
        rz     = '0;
        rq     = '0;
        for (int l = 0; l < 3; l++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                vals[l][i] = '0;
            end
        end
        case (k) inside
            ST_PROD:
            begin
                o.ok = 1'b1;
                for (int i = 0; i < 3; i++)
                begin
                    o.d[i] = 33'(p.src[i]) - 33'(p.lis[i]);
                end
                o.pr[0] = 32'(p.f[1]) * 32'(wv[2]);
                o.pr[1] = 32'(p.f[2]) * 32'(wv[1]);
                o.pr[2] = 32'(p.f[2]) * 32'(wv[0]);
                o.pr[3] = 32'(p.f[0]) * 32'(wv[2]);
                o.pr[4] = 32'(p.f[0]) * 32'(wv[1]);
                o.pr[5] = 32'(p.f[1]) * 32'(wv[0]);
            end
            ST_ABS:
            begin
                // right = forward x up, then sign and magnitude of all lanes
                for (int i = 0; i < 3; i++)
                begin
                    vals[LANE_DIR][i]   = 34'(p.d[i]);
                    vals[LANE_FWD][i]   = 34'(p.f[i]);
                    vals[LANE_RIGHT][i] = 34'(p.pr[2*i]) - 34'(p.pr[2*i+1]);
                end
                for (int l = 0; l < 3; l++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        o.neg[l][i] = vals[l][i][33];
                        o.m[l][i]   = vals[l][i][33] ? 33'(-vals[l][i]) : 33'(vals[l][i]);
                    end
                end
            end
            ST_SQ:
            begin
                // prescale large vectors by four, then square
                for (int l = 0; l < 3; l++)
                begin
                    big = (|p.m[l][0][32:30]) | (|p.m[l][1][32:30]) | (|p.m[l][2][32:30]);
                    for (int i = 0; i < 3; i++)
                    begin
                        o.m[l][i]  = big ? (p.m[l][i] >> 2) : p.m[l][i];
                        o.sq[l][i] = 60'(o.m[l][i][29:0]) * 60'(o.m[l][i][29:0]);
                    end
                end
            end
            ST_SUM:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    o.m2[l] = 62'(p.sq[l][0]) + 62'(p.sq[l][1]) + 62'(p.sq[l][2]);
                end
                o.ok = p.ok && (o.m2[0] != '0) && (o.m2[1] != '0) && (o.m2[2] != '0);
            end
            ST_NORM:
            begin
                // even left shift that puts the squared length in [2^60, 2^62)
                for (int l = 0; l < 3; l++)
                begin
                    t  = p.m2[l];
                    sh = '0;
                    if (t[61:30] == '0)
                    begin
                        t  = t << 32;
                        sh = sh + 5'd16;
                    end
                    if (t[61:46] == '0)
                    begin
                        t  = t << 16;
                        sh = sh + 5'd8;
                    end
                    if (t[61:54] == '0)
                    begin
                        t  = t << 8;
                        sh = sh + 5'd4;
                    end
                    if (t[61:58] == '0)
                    begin
                        t  = t << 4;
                        sh = sh + 5'd2;
                    end
                    if (t[61:60] == '0)
                    begin
                        t  = t << 2;
                        sh = sh + 5'd1;
                    end
                    o.s[l]  = sh;
                    o.sv[l] = {1'b0, t};
                    o.sr[l] = '0;
                end
            end
            [ST_ROOT : ST_ROOT + ROOT_STEPS - 1], [ST_ROOT2 : ST_ROOT2 + ROOT_STEPS - 1]:
            begin
                // one bit of the square root per stage
                j = (k >= ST_ROOT2) ? (k - ST_ROOT2) : (k - ST_ROOT);
                for (int l = 0; l < 3; l++)
                begin
                    bit_b = 63'(1) << (60 - 2 * j);
                    trial = p.sr[l] + bit_b;
                    if (p.sv[l] >= trial)
                    begin
                        o.sv[l] = p.sv[l] - trial;
                        o.sr[l] = (p.sr[l] >> 1) + bit_b;
                    end
                    else
                    begin
                        o.sr[l] = p.sr[l] >> 1;
                    end
                end
            end
            ST_DIVI:
            begin
                // dividend is (m << s) << 30, its top bits seed the remainder
                for (int l = 0; l < 3; l++)
                begin
                    o.n[l] = p.sr[l][30:0];
                    for (int i = 0; i < 3; i++)
                    begin
                        mshift       = 62'(p.m[l][i][29:0]) << p.s[l];
                        o.mm[l][i]   = mshift[30:0];
                        o.rem[l][i]  = {2'b00, mshift[30:1]};
                        o.q[l][i]    = '0;
                    end
                end
            end
            [ST_DIV : ST_DIV + DIV_STEPS - 1]:
            begin
                // one quotient bit per stage, restoring division
                j = 30 - (k - ST_DIV);
                for (int l = 0; l < 3; l++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rem2 = {p.rem[l][i][30:0], (j == 30) ? p.mm[l][i][0] : 1'b0};
                        if (rem2 >= {1'b0, p.n[l]})
                        begin
                            o.rem[l][i]  = rem2 - {1'b0, p.n[l]};
                            o.q[l][i][j] = 1'b1;
                        end
                        else
                        begin
                            o.rem[l][i] = rem2;
                        end
                    end
                end
            end
            ST_SIGN:
            begin
                for (int l = 0; l < 3; l++)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        o.u[l][i] = p.neg[l][i] ? -$signed({1'b0, p.q[l][i]})
                                                : $signed({1'b0, p.q[l][i]});
                    end
                end
            end
            ST_MUL1:
            begin
                // up = right x forward, and the direction dots with forward and right
                o.pa[0] = 64'(p.u[LANE_RIGHT][1]) * 64'(p.u[LANE_FWD][2]);
                o.pa[1] = 64'(p.u[LANE_RIGHT][2]) * 64'(p.u[LANE_FWD][1]);
                o.pa[2] = 64'(p.u[LANE_RIGHT][2]) * 64'(p.u[LANE_FWD][0]);
                o.pa[3] = 64'(p.u[LANE_RIGHT][0]) * 64'(p.u[LANE_FWD][2]);
                o.pa[4] = 64'(p.u[LANE_RIGHT][0]) * 64'(p.u[LANE_FWD][1]);
                o.pa[5] = 64'(p.u[LANE_RIGHT][1]) * 64'(p.u[LANE_FWD][0]);
                for (int i = 0; i < 3; i++)
                begin
                    o.pa[6+i] = 64'(p.u[LANE_DIR][i]) * 64'(p.u[LANE_FWD][i]);
                    o.pa[9+i] = 64'(p.u[LANE_DIR][i]) * 64'(p.u[LANE_RIGHT][i]);
                end
            end
            ST_SUM1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    acc     = p.pa[2*i] - p.pa[2*i+1];
                    o.up[i] = 33'(acc >>> 30);
                end
                acc = p.pa[6] + p.pa[7] + p.pa[8];
                o.a = 34'(acc >>> 30);
                acc = p.pa[9] + p.pa[10] + p.pa[11];
                o.b = 34'(acc >>> 30);
            end
            ST_MUL2:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    o.pa[i] = 64'(p.u[LANE_DIR][i]) * 64'(p.up[i]);
                end
            end
            ST_SUM2:
            begin
                acc = p.pa[0] + p.pa[1] + p.pa[2];
                o.c = 33'(acc >>> 30);
            end
            ST_SQC:
            begin
                if (p.c > Q30_ONE)
                begin
                    o.c = Q30_ONE;
                end
                else if (p.c < -Q30_ONE)
                begin
                    o.c = -Q30_ONE;
                end
                o.pa[0] = 64'(o.c) * 64'(o.c);
            end
            ST_ELI:
            begin
                // cosine of elevation: sqrt(1 - c^2) in Q30
                acc     = 64'sh1000_0000_0000_0000 - p.pa[0];
                o.sv[0] = acc[62:0];
                o.sr[0] = '0;
            end
            ST_PRE:
            begin
                // fold the left half plane onto the right by a quarter turn
                o.az_en = (p.a != '0) || (p.b != '0);
                for (int l = 0; l < 2; l++)
                begin
                    xin = (l == 0) ? 36'(p.a) : $signed({5'b0, p.sr[0][30:0]});
                    yin = (l == 0) ? 36'(p.b) : 36'(p.c);
                    if (xin < 0)
                    begin
                        if (yin >= 0)
                        begin
                            o.cx[l] = yin;
                            o.cy[l] = -xin;
                            o.cz[l] = DEG90;
                        end
                        else
                        begin
                            o.cx[l] = -yin;
                            o.cy[l] = xin;
                            o.cz[l] = -DEG90;
                        end
                    end
                    else
                    begin
                        o.cx[l] = xin;
                        o.cy[l] = yin;
                        o.cz[l] = '0;
                    end
                end
            end
            [ST_CORD : ST_CORD + CORDIC_STAGES - 1]:
            begin
                // one vectoring rotation per stage
                j = k - ST_CORD;
                for (int l = 0; l < 2; l++)
                begin
                    dx = p.cy[l] >>> j;
                    dy = p.cx[l] >>> j;
                    if (p.cy[l] > 0)
                    begin
                        o.cx[l] = p.cx[l] + dx;
                        o.cy[l] = p.cy[l] - dy;
                        o.cz[l] = p.cz[l] + $signed({4'b0, ATAN_STEP[j]});
                    end
                    else
                    begin
                        o.cx[l] = p.cx[l] - dx;
                        o.cy[l] = p.cy[l] + dy;
                        o.cz[l] = p.cz[l] - $signed({4'b0, ATAN_STEP[j]});
                    end
                end
            end
            ST_OUT:
            begin
                // round half up to 1/128 degree and clamp
                rz = 34'(p.cz[0]) + 34'sd32768;
                rq = 18'(rz >>> 16);
                if (rq > AZ_LIMIT)
                begin
                    rq = AZ_LIMIT;
                end
                else if (rq < -AZ_LIMIT)
                begin
                    rq = -AZ_LIMIT;
                end
                o.az = (p.ok && p.az_en) ? rq[15:0] : '0;
                rz = 34'(p.cz[1]) + 34'sd32768;
                rq = 18'(rz >>> 16);
                if (rq > EL_LIMIT)
                begin
                    rq = EL_LIMIT;
                end
                else if (rq < -EL_LIMIT)
                begin
                    rq = -EL_LIMIT;
                end
                o.el = p.ok ? rq[14:0] : '0;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg[0] <= UP_X_RESET;
            up_reg[1] <= UP_Y_RESET;
            up_reg[2] <= UP_Z_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UP_X: up_reg[0] <= cfg_data;
                CFG_UP_Y: up_reg[1] <= cfg_data;
                CFG_UP_Z: up_reg[2] <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb
    begin
        adv[NST] = !vld_reg[NST] || m_tready;
        for (int k = NST - 1; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_tready = adv[0];

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int k = 1; k <= NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                pipe_reg[0].src[i] <= s_tdata[32*i +: 32];
                pipe_reg[0].lis[i] <= s_tdata[96 + 32*i +: 32];
                pipe_reg[0].f[i]   <= s_tdata[192 + 16*i +: 16];
            end
        end
    end

    // datapath stages
    for (genvar k = 0; k < NST; k++)
    begin : g_stage
        always_ff @(posedge clk)
        begin
            if (adv[k+1])
            begin
                pipe_reg[k+1] <= step_fn(k, pipe_reg[k], up_reg);
            end
        end
    end

    // result transaction
    assign m_tvalid = vld_reg[NST];
    assign m_tdata  = {1'b0, pipe_reg[NST].el, pipe_reg[NST].az};
    assign m_tuser  = !pipe_reg[NST].ok;

    // a degenerate result carries zero angles
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("degenerate result with nonzero angles");

    // angles stay inside their clamp limits
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16'sd23040)
                  && ($signed(m_tdata[15:0]) >= -16'sd23040)
                  && ($signed(m_tdata[30:16]) <= 15'sd11520)
                  && ($signed(m_tdata[30:16]) >= -15'sd11520))
        else $error("angle outside limits");

    // input back pressure only when the whole pipe is full behind a stalled output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> vld_reg[0] && m_tvalid && !m_tready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

### tb/head_frame_direction_core_tb.sv
`timescale 1ns / 1ps

module head_frame_direction_core_tb;
    import hfd_pkg::*;

    localparam int STAGES  = 16;
    localparam int LATENCY = 108 + STAGES;

    typedef longint vec3_t [3];

    typedef struct {
        logic signed [31:0] src [3];
        logic signed [31:0] lis [3];
        logic signed [15:0] fac [3];
    } query_t;

    typedef struct {
        logic signed [15:0] az;
        logic signed [14:0] el;
        logic               degen;
    } angles_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic [239:0] s_tdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  m_tdata;
    logic         m_tuser;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    // current world up as the block holds it
    logic signed [15:0] up_vec [3];

    angles_t angle_queue [$];
    int      n_fail = 0;
    int      n_checked = 0;
    int      n_degen = 0;
    int      n_sent = 0;
    bit      no_stall = 1'b0;
    int      stall_left = 0;

    head_frame_direction_core #(.CORDIC_STAGES(STAGES)) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // integer square root, floor
    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // unit vector in q30, returns zero on zero length
    function automatic bit normalize(input vec3_t v, output vec3_t o);
        longint unsigned mag [3];
        longint unsigned m2;
        longint unsigned n;
        longint q;
        int s;
        bit big;
        m2 = 0;
        s = 0;
        big = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mag[i] >= (64'd1 << 30))
                big = 1'b1;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (big)
                mag[i] = mag[i] >> 2;
            m2 = m2 + mag[i] * mag[i];
        end
        for (int i = 0; i < 3; i++)
            o[i] = 0;
        if (m2 == 0)
            return 1'b0;
        while (s < 30 && m2 < (64'd1 << (60 - 2 * s)))
            s++;
        n = root_floor(m2 << (2 * s));
        for (int i = 0; i < 3; i++)
        begin
            q = longint'(((mag[i] << s) << 30) / n);
            o[i] = (v[i] < 0) ? -q : q;
        end
        return 1'b1;
    endfunction

    // vectoring rotation, angle in 2^-23 degree
    function automatic longint rotate_atan(input longint y, input longint x);
        longint z;
        longint t;
        longint dx;
        longint dy;
        z = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = longint'(DEG90);
            end
            else
            begin
                x = -y;
                y = t;
                z = -longint'(DEG90);
            end
        end
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(ATAN_STEP[i]);
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(ATAN_STEP[i]);
            end
        end
        return z;
    endfunction

    function automatic longint round_clamp(input longint z, input longint lim);
        longint q;
        q = (z + 32768) >>> 16;
        if (q > lim)
            q = lim;
        if (q < -lim)
            q = -lim;
        return q;
    endfunction

    // head frame angles of one query under the current world up
    function automatic angles_t head_angles(input query_t qy);
        vec3_t d, f, w, rr, dn, fn, rn, un;
        longint a, b, c, h;
        angles_t res;
        bit ok;
        res.az = '0;
        res.el = '0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = longint'(qy.src[i]) - longint'(qy.lis[i]);
            f[i] = longint'(qy.fac[i]);
            w[i] = longint'(up_vec[i]);
        end
        rr[0] = f[1] * w[2] - f[2] * w[1];
        rr[1] = f[2] * w[0] - f[0] * w[2];
        rr[2] = f[0] * w[1] - f[1] * w[0];
        ok = normalize(d, dn);
        ok = normalize(f, fn) && ok;
        ok = normalize(rr, rn) && ok;
        if (ok)
        begin
            un[0] = (rn[1] * fn[2] - rn[2] * fn[1]) >>> 30;
            un[1] = (rn[2] * fn[0] - rn[0] * fn[2]) >>> 30;
            un[2] = (rn[0] * fn[1] - rn[1] * fn[0]) >>> 30;
            a = (dn[0] * fn[0] + dn[1] * fn[1] + dn[2] * fn[2]) >>> 30;
            b = (dn[0] * rn[0] + dn[1] * rn[1] + dn[2] * rn[2]) >>> 30;
            c = (dn[0] * un[0] + dn[1] * un[1] + dn[2] * un[2]) >>> 30;
            if (a != 0 || b != 0)
                res.az = 16'(round_clamp(rotate_atan(b, a), 23040));
            if (c > longint'(Q30_ONE))
                c = longint'(Q30_ONE);
            if (c < -longint'(Q30_ONE))
                c = -longint'(Q30_ONE);
            h = longint'(root_floor(longint'(Q30_ONE) * longint'(Q30_ONE) - c * c));
            res.el = 15'(round_clamp(rotate_atan(c, h), 11520));
        end
        res.degen = ~ok;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_fail++;
    endtask

    // sink side: random stall per transaction, result checking
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            if (angle_queue.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                angles_t want;
                want = angle_queue.pop_front();
                if ($signed(m_tdata[15:0]) != want.az)
                    report_mismatch("azimuth", $signed(m_tdata[15:0]), want.az);
                if ($signed(m_tdata[30:16]) != want.el)
                    report_mismatch("elevation", $signed(m_tdata[30:16]), want.el);
                if (m_tuser != want.degen)
                    report_mismatch("degenerate", m_tuser, want.degen);
                n_checked++;
            end
            stall_left = no_stall ? 0 : $urandom_range(0, 4);
        end
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            m_tready <= 1'b1;
    end

    // send one query, predict on acceptance
    task automatic send_query(input query_t qy, input bit gapless);
        int gap;
        angles_t want;
        gap = gapless ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {qy.fac[2], qy.fac[1], qy.fac[0], qy.lis[2], qy.lis[1], qy.lis[0],
                    qy.src[2], qy.src[1], qy.src[0]};
        want = head_angles(qy);
        do
            @(posedge clk);
        while (!s_tready);
        angle_queue.push_back(want);
        n_degen += want.degen;
        n_sent++;
    endtask

    // drop valid and wait for the pipeline to drain
    task automatic drain;
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    task automatic write_up(input logic [1:0] idx, input logic signed [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        up_vec[idx] = val;
        @(posedge clk);
    endtask

    task automatic set_up(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic signed [15:0] z);
        drain();
        write_up(CFG_UP_X, x);
        write_up(CFG_UP_Y, y);
        write_up(CFG_UP_Z, z);
    endtask

    function automatic query_t make_query(input int sx, input int sy, input int sz,
                                          input int lx, input int ly, input int lz,
                                          input int fx, input int fy, input int fz);
        query_t qy;
        qy.src[0] = sx; qy.src[1] = sy; qy.src[2] = sz;
        qy.lis[0] = lx; qy.lis[1] = ly; qy.lis[2] = lz;
        qy.fac[0] = 16'(fx); qy.fac[1] = 16'(fy); qy.fac[2] = 16'(fz);
        return qy;
    endfunction

    function automatic logic signed [31:0] rand_pos(input int mode);
        case (mode)
            0: return $urandom;
            1: return $signed($urandom_range(0, 2097151)) - 1048576;
            2: return $signed($urandom_range(0, 32)) - 16;
            default: return $signed($urandom_range(0, 1 << 28)) - (1 << 27);
        endcase
    endfunction

    function automatic query_t rand_query;
        query_t qy;
        int mode;
        int fmode;
        mode = $urandom_range(0, 3);
        fmode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            qy.lis[i] = rand_pos(mode);
            qy.src[i] = ($urandom_range(0, 1) != 0 && mode != 0) ?
                        qy.lis[i] + rand_pos(2) : rand_pos(mode);
            if (fmode < 6)
                qy.fac[i] = 16'($urandom);
            else if (fmode < 8)
                qy.fac[i] = 16'($signed($urandom_range(0, 8)) - 4);
            else if (fmode == 8)
                qy.fac[i] = 16'(up_vec[i] * ($urandom_range(0, 1) ? 1 : -1));
            else
                qy.fac[i] = '0;
        end
        // occasional coincident source and listener
        if ($urandom_range(0, 29) == 0)
            qy.src = qy.lis;
        return qy;
    endfunction

    task automatic run_random(input int count);
        for (int k = 0; k < count; k++)
        begin
            no_stall = (k % 100) >= 80;
            send_query(rand_query(), (k % 100) >= 70 && (k % 100) < 85);
        end
        no_stall = 1'b0;
    endtask

    // field extremes and each special geometry under the default y-up frame
    task automatic test_directed;
        send_query(make_query(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                              32'h80000000, 32'h80000000, 32'h80000000,
                              32767, 32767, 32767), 1'b0);
        send_query(make_query(32'h80000000, 0, 32'h80000000,
                              32'h7fffffff, 0, 32'h7fffffff,
                              -32768, -32768, -32768), 1'b0);
        send_query(make_query(65536, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0);
        send_query(make_query(-65536, 0, 0, 0, 0, 0, 0, 0, 1), 1'b0);
        send_query(make_query(0, 0, -65536, 0, 0, 0, 0, 0, 1), 1'b0);
        send_query(make_query(1, 0, -1, 0, 0, 0, 0, 0, 1), 1'b0);
        send_query(make_query(-1, 0, -1, 0, 0, 0, 0, 0, 1), 1'b0);
        // direction straight up and straight down
        send_query(make_query(0, 655360, 0, 0, 0, 0, 0, 0, 1), 1'b0);
        send_query(make_query(0, -1, 0, 0, 0, 0, 3, 0, 4), 1'b0);
        // source at the listener
        send_query(make_query(12345, -777, 42, 12345, -777, 42, 1, 0, 0), 1'b0);
        // zero facing
        send_query(make_query(65536, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        // facing along up and against up
        send_query(make_query(65536, 0, 0, 0, 0, 0, 0, 5, 0), 1'b0);
        send_query(make_query(65536, 0, 0, 0, 0, 0, 0, -32768, 0), 1'b0);
        send_query(make_query(100, 200, 300, -100, -200, -300, 1, 1, 1), 1'b1);
        send_query(make_query(32'h40000000, 32'hc0000000, 5, 0, 0, 0, -1, 2, -3), 1'b1);
        send_query(make_query(1, 1, 1, 0, 0, 0, -32768, 32767, 1), 1'b1);
    endtask

    // random traffic under a sweep of world up vectors, extremes included
    task automatic test_up_sweep;
        set_up(16'sd0, 16'sd16384, 16'sd0);
        run_random(250);
        set_up(16'sd0, 16'sd0, 16'sd32767);
        run_random(100);
        set_up(-16'sd32768, 16'sd0, 16'sd0);
        run_random(100);
        set_up(16'sd32767, -16'sd32768, 16'sd32767);
        run_random(100);
        // zero up, every item is degenerate
        set_up(16'sd0, 16'sd0, 16'sd0);
        run_random(40);
        set_up(16'($urandom), 16'($urandom), 16'($urandom));
        run_random(120);
        set_up(16'sd1, -16'sd1, 16'sd0);
        run_random(100);
    endtask

    initial
    begin
        up_vec[0] = UP_X_RESET;
        up_vec[1] = UP_Y_RESET;
        up_vec[2] = UP_Z_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_up_sweep();
        drain();
        $display("sent %0d queries over 7 world up settings, %0d results checked",
                 n_sent, n_checked);
        $display("%0d degenerate frames seen, %0d mismatches", n_degen, n_fail);
        if (n_fail == 0 && angle_queue.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d results outstanding", angle_queue.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
